/* hw/rtl/clock_display_serial_master_assert.svh */
// Assertion macros shared by the checker of the clock display serial master.
`ifndef CLOCK_DISPLAY_SERIAL_MASTER_ASSERT_SVH
`define CLOCK_DISPLAY_SERIAL_MASTER_ASSERT_SVH

// Clocked assertion with an active-low reset that disables it.
`define CDSM_ASSERT_CR(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cdsm assertion failed");

// Same, on the standard clock and reset names.
`define CDSM_ASSERT(label, prop) \
  `CDSM_ASSERT_CR(label, clk_i, rst_ni, prop)

`endif

/* hw/rtl/cdsm_pkg.sv */
// Shared types, constants and helper functions of the clock display serial master.
`timescale 1ns / 1ps
`default_nettype none

package cdsm_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PhaseW     = 10;
  localparam int unsigned BrightW    = 3;
  localparam int unsigned CfgDataW   = 10;
  localparam int unsigned ByteIdxW   = $clog2(DigitCount + 3);
  localparam int unsigned SegIdxW    = $clog2(DigitCount);

  // Action codes of an input request
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActPower = 2'd1;
  localparam logic [1:0] ActShow  = 2'd2;

  // Configuration register indexes
  localparam logic CfgBrightness = 1'b0;
  localparam logic CfgPhaseTicks = 1'b1;

  // Link command bytes
  localparam logic [7:0] CmdDisplayOn = 8'h88;
  localparam logic [7:0] CmdData      = 8'h40;
  localparam logic [7:0] CmdAddr      = 8'hC0;
  localparam logic [7:0] SegColon     = 8'h80;

  localparam logic [6:0] ValueMax = 7'd99;

  typedef enum logic [1:0] {
    KindTick,
    KindPower,
    KindShow
  } kind_e;

  typedef struct packed {
    logic [1:0] action;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic       colon;
    logic       dio_sense;
  } req_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic ack_missing;
    logic done_res;
  } res_t;

  typedef logic [DigitCount-1:0][7:0] seg_row_t;

  // Classified request handed from the front end to the sequencer
  typedef struct packed {
    kind_e    kind;
    seg_row_t seg;
    logic     dio_sense;
  } cmd_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Tens digit of a value up to 99: multiply by 205/2048
  function automatic logic [3:0] tens_of(input logic [6:0] value);
    logic [14:0] prod;
    prod = 15'(value) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cdsm_stream_if.sv */
// Valid/ready stream channel carrying one payload per request.
`timescale 1ns / 1ps
`default_nettype none

interface cdsm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/clock_display_serial_master.sv */
// Each request is stored in the request queue, then in the result register.
// Throughput: one request per cycle; a stalled result blocks input once the queue is full.
// Phase rate: the waveform moves one phase per phase_ticks tick requests (zero acts as one).
// Reset: asynchronous, active low; idle, pins clock high / data high driven,
// brightness 7, phase_ticks 200, queue empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module clock_display_serial_master #(
  parameter int unsigned QUEUE_DEPTH = cdsm_pkg::QueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cdsm_pkg::CfgDataW-1:0] cfg_data_i,
  // request and result channels
  cdsm_stream_if.sink                   in_if,
  cdsm_stream_if.source                 out_if
);

  // Front end -> queue: classified request with its digit codes
  cdsm_pkg::cmd_t front_cmd;
  logic           front_push;
  logic           queue_full;

  // Queue -> sequencer
  cdsm_pkg::cmd_t queue_cmd;
  logic           queue_valid;
  logic           back_pop;

  // Front end: saturates hours/minutes to 99, builds segment codes, blanks
  // a leading hour zero, sets the colon bit on digit 1. Ready while the
  // queue has room, so input keeps flowing while the result side stalls,
  // up to the queue depth.
  cdsm_front u_front (
    .in_if  (in_if),
    .full_i (queue_full),
    .push_o (front_push),
    .cmd_o  (front_cmd)
  );

  // Short request queue decoupling the front end from the sequencer.
  cdsm_fifo #(
    .Depth  (QUEUE_DEPTH),
    .data_t (cdsm_pkg::cmd_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .data_o  (queue_cmd)
  );

  // Sequencer: each popped request is one step of the link state machine.
  // An idle start request begins a sequence (power-on: display-on frame,
  // data frame, address frame with blank digits; show: data frame and
  // address frame with digit codes). Every other request is a tick that
  // advances the phase divider while a sequence runs. The result register
  // pops a new request whenever it is empty or being drained.
  cdsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (back_pop),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

/* hw/rtl/cdsm_fifo.sv */
// Small register queue between the request front end and the link sequencer.
`timescale 1ns / 1ps
`default_nettype none

module cdsm_fifo #(
  parameter int unsigned Depth = cdsm_pkg::QueueDepth,
  parameter type         data_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output data_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  data_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/cdsm_front.sv */
// Request front end: classifies requests and turns hours/minutes into segment codes.
`timescale 1ns / 1ps
`default_nettype none

module cdsm_front (
  cdsm_stream_if.sink      in_if,
  input  logic             full_i,
  output logic             push_o,
  output cdsm_pkg::cmd_t   cmd_o
);

  logic [6:0] hh_sat, mm_sat;
  logic [3:0] hh_tens, mm_tens;
  logic [6:0] hh_ones, mm_ones;

  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  assign hh_sat = (in_if.payload.hours > cdsm_pkg::ValueMax) ?
                  cdsm_pkg::ValueMax : in_if.payload.hours;
  assign mm_sat = (in_if.payload.minutes > cdsm_pkg::ValueMax) ?
                  cdsm_pkg::ValueMax : in_if.payload.minutes;

  assign hh_tens = cdsm_pkg::tens_of(hh_sat);
  assign mm_tens = cdsm_pkg::tens_of(mm_sat);
  // ones = value - 10 * tens
  assign hh_ones = hh_sat - ({hh_tens, 3'b000} + {2'b00, hh_tens, 1'b0});
  assign mm_ones = mm_sat - ({mm_tens, 3'b000} + {2'b00, mm_tens, 1'b0});

  always_comb begin
    cmd_o.dio_sense = in_if.payload.dio_sense;
    cmd_o.seg       = '0;
    case (in_if.payload.action)
      cdsm_pkg::ActPower: begin
        cmd_o.kind = cdsm_pkg::KindPower;
      end
      cdsm_pkg::ActShow: begin
        cmd_o.kind   = cdsm_pkg::KindShow;
        // blank a leading hour zero
        cmd_o.seg[0] = (hh_sat >= 7'd10) ? cdsm_pkg::seg_code(hh_tens) : 8'h00;
        cmd_o.seg[1] = cdsm_pkg::seg_code(hh_ones[3:0]) |
                       (in_if.payload.colon ? cdsm_pkg::SegColon : 8'h00);
        cmd_o.seg[2] = cdsm_pkg::seg_code(mm_tens);
        cmd_o.seg[3] = cdsm_pkg::seg_code(mm_ones[3:0]);
      end
      default: begin
        cmd_o.kind = cdsm_pkg::KindTick;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/cdsm_back.sv */
// Link sequencer: phase divider, frame/byte/bit state machine, pin levels, result register.
`timescale 1ns / 1ps
`default_nettype none

module cdsm_back (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [cdsm_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic                                   cmd_valid_i,
  input  cdsm_pkg::cmd_t                         cmd_i,
  output logic                                   pop_o,
  cdsm_stream_if.source                          out_if
);

  typedef enum logic [1:0] {
    StIdle,
    StStart,
    StByte,
    StStop
  } seq_e;

  typedef struct packed {
    logic clk;
    logic dio;
    logic drv;
  } pins_t;

  localparam logic [4:0] PhStartLast = 5'd2;
  localparam logic [4:0] PhBitsEnd   = 5'd24;
  localparam logic [4:0] PhAckLow    = 5'd24;
  localparam logic [4:0] PhRelease   = 5'd25;
  localparam logic [4:0] PhAckHigh   = 5'd26;
  localparam logic [4:0] PhAckEnd    = 5'd27;
  localparam logic [4:0] PhStopDio0  = 5'd1;
  localparam logic [4:0] PhStopClk1  = 5'd2;
  localparam logic [4:0] PhStopLast  = 5'd3;

  localparam int unsigned BIW = cdsm_pkg::ByteIdxW;
  localparam logic [BIW-1:0] IdxOn     = BIW'(0);
  localparam logic [BIW-1:0] IdxData   = BIW'(1);
  localparam logic [BIW-1:0] IdxAddr   = BIW'(2);
  localparam logic [BIW-1:0] IdxSeg0   = BIW'(3);
  localparam logic [BIW-1:0] IdxLast   = BIW'(2 + cdsm_pkg::DigitCount);

  localparam logic [cdsm_pkg::BrightW-1:0] BrightReset = 3'd7;
  localparam logic [cdsm_pkg::PhaseW-1:0]  TicksReset  = 10'd200;

  seq_e                         st_q, st_d;
  logic [4:0]                   ph_q, ph_d;
  logic [BIW-1:0]               bi_q, bi_d;
  logic [7:0]                   sh_q, sh_d;
  logic [cdsm_pkg::PhaseW-1:0]  div_q, div_d;
  logic                         ack_q, ack_d;
  pins_t                        pins_q, pins_d;
  cdsm_pkg::seg_row_t           seg_q, seg_d;
  logic [cdsm_pkg::BrightW-1:0] bright_q;
  logic [cdsm_pkg::PhaseW-1:0]  ticks_q;
  logic                         out_valid_q, out_valid_d;
  cdsm_pkg::res_t               out_q, out_d;

  logic                         pop;
  logic                         done;
  logic                         apply;
  logic                         load;
  logic [BIW-1:0]               load_idx;
  logic [BIW-1:0]               seg_off;
  logic [7:0]                   load_byte;
  logic [cdsm_pkg::PhaseW-1:0]  limit;
  logic                         phase_end;

  // Pin levels for the phase that has just begun
  function automatic pins_t apply_phase(input seq_e st, input logic [4:0] p,
                                        input logic [7:0] sh, input pins_t cur);
    pins_t      r;
    logic [8:0] prod;
    logic [2:0] bit_sel;
    logic [4:0] sub;
    r       = cur;
    prod    = 9'(p) * 9'd11;          // p / 3 for p below 24
    bit_sel = prod[7:5];
    sub     = p - ({1'b0, bit_sel, 1'b0} + {2'b00, bit_sel});
    unique case (st)
      StStart: begin
        r.drv = 1'b1;
        r.clk = (p < PhStartLast);
        r.dio = (p == '0);
      end
      StByte: begin
        if (p < PhBitsEnd) begin
          case (sub)
            5'd0: begin
              r.clk = 1'b0;
              r.drv = 1'b1;
            end
            5'd1:    r.dio = sh[bit_sel];
            default: r.clk = 1'b1;
          endcase
        end else if (p == PhAckLow) begin
          r.clk = 1'b0;
        end else if (p == PhRelease) begin
          r.drv = 1'b0;
        end else if (p == PhAckHigh) begin
          r.clk = 1'b1;
        end else begin
          r.clk = 1'b0;
        end
      end
      StStop: begin
        if (p == '0) begin
          r.clk = 1'b0;
          r.drv = 1'b1;
        end else if (p == PhStopDio0) begin
          r.dio = 1'b0;
        end else if (p == PhStopClk1) begin
          r.clk = 1'b1;
        end else begin
          r.dio = 1'b1;
        end
      end
      StIdle: r = '1;
    endcase
    return r;
  endfunction

  assign pop   = cmd_valid_i && (!out_valid_q || out_if.ready);
  assign pop_o = pop;

  assign limit     = (ticks_q == '0) ? cdsm_pkg::PhaseW'(1) : ticks_q;
  assign phase_end = ({1'b0, div_q} + 1'b1) >= {1'b0, limit};

  // Byte fetch for the next byte of the sequence
  assign seg_off = load_idx - IdxSeg0;
  always_comb begin
    if (load_idx == IdxOn) begin
      load_byte = cdsm_pkg::CmdDisplayOn | {5'b00000, bright_q};
    end else if (load_idx == IdxData) begin
      load_byte = cdsm_pkg::CmdData;
    end else if (load_idx == IdxAddr) begin
      load_byte = cdsm_pkg::CmdAddr;
    end else if (load_idx <= IdxLast) begin
      load_byte = seg_q[seg_off[cdsm_pkg::SegIdxW-1:0]];
    end else begin
      load_byte = 8'h00;
    end
  end

  always_comb begin
    st_d     = st_q;
    ph_d     = ph_q;
    bi_d     = bi_q;
    sh_d     = sh_q;
    div_d    = div_q;
    ack_d    = ack_q;
    seg_d    = seg_q;
    done     = 1'b0;
    apply    = 1'b0;
    load     = 1'b0;
    load_idx = bi_q;

    if (pop) begin
      if (st_q == StIdle && cmd_i.kind != cdsm_pkg::KindTick) begin
        seg_d = cmd_i.seg;
        bi_d  = (cmd_i.kind == cdsm_pkg::KindPower) ? IdxOn : IdxData;
        ack_d = 1'b0;
        div_d = '0;
        st_d  = StStart;
        ph_d  = '0;
        apply = 1'b1;
      end else if (st_q != StIdle) begin
        if (phase_end) begin
          div_d = '0;
          apply = 1'b1;
          unique case (st_q)
            StStart: begin
              if (ph_q >= PhStartLast) begin
                load = 1'b1;
              end else begin
                ph_d = ph_q + 1'b1;
              end
            end
            StByte: begin
              if (ph_q == PhAckHigh && cmd_i.dio_sense) begin
                ack_d = 1'b1;
              end
              if (ph_q >= PhAckEnd) begin
                if (bi_q == IdxOn || bi_q == IdxData || bi_q == IdxLast) begin
                  st_d = StStop;
                  ph_d = '0;
                end else begin
                  bi_d     = bi_q + 1'b1;
                  load_idx = bi_q + 1'b1;
                  load     = 1'b1;
                end
              end else begin
                ph_d = ph_q + 1'b1;
              end
            end
            StStop: begin
              if (ph_q >= PhStopLast) begin
                if (bi_q >= IdxLast) begin
                  st_d = StIdle;
                  ph_d = '0;
                  bi_d = '0;
                  done = 1'b1;
                end else begin
                  bi_d = bi_q + 1'b1;
                  st_d = StStart;
                  ph_d = '0;
                end
              end else begin
                ph_d = ph_q + 1'b1;
              end
            end
            StIdle: ;
          endcase
        end else begin
          div_d = div_q + 1'b1;
        end
      end
    end

    if (load) begin
      st_d = StByte;
      ph_d = '0;
      sh_d = load_byte;
    end
    pins_d = apply ? apply_phase(st_d, ph_d, sh_d, pins_q) : pins_q;
  end

  always_comb begin
    out_d.clk_level   = pins_d.clk;
    out_d.dio_level   = pins_d.dio;
    out_d.dio_drive   = pins_d.drv;
    out_d.busy_res    = (st_d != StIdle);
    out_d.ack_missing = ack_d;
    out_d.done_res    = done;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      ph_q        <= '0;
      bi_q        <= '0;
      div_q       <= '0;
      ack_q       <= 1'b0;
      pins_q      <= '1;
      bright_q    <= BrightReset;
      ticks_q     <= TicksReset;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      bi_q        <= bi_d;
      div_q       <= div_d;
      ack_q       <= ack_d;
      pins_q      <= pins_d;
      out_valid_q <= out_valid_d;
      if (pop) begin
        out_q <= out_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cdsm_pkg::CfgBrightness: bright_q <= cfg_data_i[cdsm_pkg::BrightW-1:0];
          cdsm_pkg::CfgPhaseTicks: ticks_q  <= cfg_data_i[cdsm_pkg::PhaseW-1:0];
        endcase
      end
    end
  end

  // Digit codes and shift byte are always written before use
  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
    sh_q  <= sh_d;
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

endmodule

`default_nettype wire

/* hw/rtl/cdsm_checker.sv */
// Port-level checker of the clock display serial master, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "clock_display_serial_master_assert.svh"

module cdsm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid,
  input logic           out_ready,
  input cdsm_pkg::res_t out_payload
);

  // A stalled result holds
  `CDSM_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_payload)))

  // The step that finishes a sequence leaves the block idle
  `CDSM_ASSERT(a_done_idle, (out_valid && out_payload.done_res) |-> !out_payload.busy_res)

  // While idle the clock and data lines are high and data is driven
  `CDSM_ASSERT(a_idle_pins, (out_valid && !out_payload.busy_res) |-> (out_payload.clk_level && out_payload.dio_level && out_payload.dio_drive))

  // The data line is only released while a sequence runs
  `CDSM_ASSERT(a_release_busy, (out_valid && !out_payload.dio_drive) |-> out_payload.busy_res)

endmodule

bind clock_display_serial_master cdsm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for the clock display serial master: directed table, then random requests.
`timescale 1ns / 1ps

module tb;

  // Spare action code; the block treats it as a plain tick.
  localparam logic [1:0] ActSpare = 2'd3;

  localparam int CfgW = cdsm_pkg::CfgDataW;

  // Cycle budget.
  localparam int CycleLimit = 400_000;

  // Sequencer phase numbers inside one byte: 8 bits of 3 phases, then the ack slot.
  localparam logic [4:0] BitPhases  = 5'd24;
  localparam logic [4:0] AckRelease = 5'd25;
  localparam logic [4:0] AckSample  = 5'd26;
  localparam logic [4:0] ByteEnd    = 5'd27;

  // Byte numbering of a full power-on sequence: display-on, data cmd, addr cmd, digits.
  localparam logic [3:0] ByteOn    = 4'd0;
  localparam logic [3:0] ByteData  = 4'd1;
  localparam logic [3:0] ByteAddr  = 4'd2;
  localparam logic [3:0] ByteDigit = 4'd3;
  localparam logic [3:0] ByteLast  = 4'(cdsm_pkg::DigitCount + 2);

  // Segment font, digits 0..9.
  localparam logic [7:0] SegFont [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  // Result words readable at a glance: clk dio drv | busy ack done
  localparam cdsm_pkg::res_t ResIdle  = 6'b111_000;
  localparam cdsm_pkg::res_t ResStart = 6'b111_100;

  typedef enum logic [1:0] {
    LinkIdle,
    LinkStart,
    LinkByte,
    LinkStop
  } link_e;

  // One directed row: the request, whether to tick the sequence out afterwards,
  // and a hand-typed result where one is obvious.
  typedef struct packed {
    logic [1:0]     action;
    logic [6:0]     hours;
    logic [6:0]     minutes;
    logic           colon;
    logic           sense;
    logic           drain;
    logic           typed;
    cdsm_pkg::res_t want;
  } row_t;

  localparam int PlanLen = 11;
  localparam row_t Plan [PlanLen] = '{
    // idle ticks right after reset: pins parked high, nothing busy
    '{cdsm_pkg::ActTick,  7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, ResIdle},
    '{ActSpare,           7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b1, ResIdle},
    // power-on puts start phase 0 on the pins at once
    '{cdsm_pkg::ActPower, 7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b1, ResStart},
    // show while busy is dropped and just ticks
    '{cdsm_pkg::ActShow,  7'd12,  7'd34,  1'b0, 1'b0, 1'b1, 1'b0, ResIdle},
    // leading hour zero blanked
    '{cdsm_pkg::ActShow,  7'd0,   7'd0,   1'b0, 1'b0, 1'b1, 1'b1, ResStart},
    '{cdsm_pkg::ActShow,  7'd9,   7'd59,  1'b1, 1'b0, 1'b1, 1'b0, ResIdle},
    // both fields saturate, every ack slot reads high
    '{cdsm_pkg::ActShow,  7'd127, 7'd127, 1'b1, 1'b1, 1'b1, 1'b0, ResIdle},
    // sticky ack flag survives into idle
    '{cdsm_pkg::ActTick,  7'd0,   7'd0,   1'b0, 1'b0, 1'b0, 1'b0, ResIdle},
    // new sequence clears the flag
    '{cdsm_pkg::ActShow,  7'd10,  7'd5,   1'b0, 1'b0, 1'b1, 1'b0, ResIdle},
    '{cdsm_pkg::ActPower, 7'd0,   7'd0,   1'b0, 1'b1, 1'b1, 1'b0, ResIdle},
    '{cdsm_pkg::ActTick,  7'd0,   7'd0,   1'b0, 1'b1, 1'b0, 1'b0, ResIdle}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [CfgW-1:0] cfg_data;

  cdsm_stream_if #(.payload_t(cdsm_pkg::req_t)) req_ch ();
  cdsm_stream_if #(.payload_t(cdsm_pkg::res_t)) res_ch ();

  // Shadow of the sequencer, kept in step with every accepted request.
  logic [2:0] bright_q;
  logic [9:0] ticks_q;
  link_e      link_st;
  logic [3:0] byte_no;
  logic [4:0] phase_no;
  logic [7:0] shift_q;
  logic [7:0] digit_seg [cdsm_pkg::DigitCount];
  logic [9:0] div_q;
  logic       ack_bad;
  logic       pin_clk, pin_dio, pin_drv;

  cdsm_pkg::res_t wanted_res_q [$];
  int   errors = 0;
  int   cycles = 0;
  bit   steady = 1'b0;   // when set, neither side inserts bubbles

  clock_display_serial_master dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (req_ch),
    .out_if     (res_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Pin-level predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] link_byte(input logic [3:0] idx);
    if (idx == ByteOn) return cdsm_pkg::CmdDisplayOn | {5'd0, bright_q};
    if (idx == ByteData) return cdsm_pkg::CmdData;
    if (idx == ByteAddr) return cdsm_pkg::CmdAddr;
    if (idx >= ByteDigit && idx <= ByteLast) return digit_seg[idx - ByteDigit];
    return 8'h00;
  endfunction

  // Frames close after the display-on byte, the data command, and the last digit.
  function automatic logic frame_last(input logic [3:0] idx);
    return idx == ByteOn || idx == ByteData || idx == ByteLast;
  endfunction

  // Put the pin levels of the current phase on the shadow pins.
  function automatic void drive_phase();
    case (link_st)
      LinkStart: begin
        pin_drv = 1'b1;
        pin_clk = phase_no < 5'd2;
        pin_dio = phase_no == 5'd0;
      end
      LinkByte: begin
        if (phase_no < BitPhases) begin
          // each bit: clock low, data set, clock high
          case (phase_no % 3)
            0: begin
              pin_clk = 1'b0;
              pin_drv = 1'b1;
            end
            1: pin_dio = shift_q[phase_no / 3];
            default: pin_clk = 1'b1;
          endcase
        end else if (phase_no == AckRelease) begin
          pin_drv = 1'b0;
        end else if (phase_no == AckSample) begin
          pin_clk = 1'b1;
        end else begin
          pin_clk = 1'b0;
        end
      end
      LinkStop: begin
        if (phase_no == 5'd0) begin
          pin_clk = 1'b0;
          pin_drv = 1'b1;
        end else if (phase_no == 5'd1) begin
          pin_dio = 1'b0;
        end else if (phase_no == 5'd2) begin
          pin_clk = 1'b1;
        end else begin
          pin_dio = 1'b1;
        end
      end
      default: begin
        pin_clk = 1'b1;
        pin_dio = 1'b1;
        pin_drv = 1'b1;
      end
    endcase
  endfunction

  function automatic void load_byte();
    link_st  = LinkByte;
    phase_no = '0;
    shift_q  = link_byte(byte_no);
  endfunction

  // Close the running phase; returns 1 when the whole sequence has ended.
  function automatic logic close_phase(input logic sense);
    logic done;
    done = 1'b0;
    case (link_st)
      LinkStart: begin
        if (phase_no >= 5'd2) load_byte();
        else phase_no++;
      end
      LinkByte: begin
        // ack slot is sampled as its clock-high phase ends
        if (phase_no == AckSample && sense) ack_bad = 1'b1;
        if (phase_no >= ByteEnd) begin
          if (frame_last(byte_no)) begin
            link_st  = LinkStop;
            phase_no = '0;
          end else begin
            byte_no++;
            load_byte();
          end
        end else begin
          phase_no++;
        end
      end
      LinkStop: begin
        if (phase_no >= 5'd3) begin
          if (byte_no >= ByteLast) begin
            link_st  = LinkIdle;
            phase_no = '0;
            byte_no  = '0;
            done     = 1'b1;
          end else begin
            byte_no++;
            link_st  = LinkStart;
            phase_no = '0;
          end
        end else begin
          phase_no++;
        end
      end
      default: ;
    endcase
    drive_phase();
    return done;
  endfunction

  // Advance the shadow by one accepted request and return the pins it leaves.
  function automatic cdsm_pkg::res_t predict_pins(input cdsm_pkg::req_t r);
    cdsm_pkg::res_t o;
    logic        done;
    int          hh, mm;
    logic [10:0] nxt, lim;
    done = 1'b0;
    if (link_st == LinkIdle &&
        (r.action == cdsm_pkg::ActPower || r.action == cdsm_pkg::ActShow)) begin
      if (r.action == cdsm_pkg::ActPower) begin
        foreach (digit_seg[i]) digit_seg[i] = 8'h00;
        byte_no = ByteOn;
      end else begin
        hh = (r.hours > cdsm_pkg::ValueMax) ? cdsm_pkg::ValueMax : r.hours;
        mm = (r.minutes > cdsm_pkg::ValueMax) ? cdsm_pkg::ValueMax : r.minutes;
        digit_seg[0] = (hh >= 10) ? SegFont[hh / 10] : 8'h00;
        digit_seg[1] = SegFont[hh % 10] | (r.colon ? cdsm_pkg::SegColon : 8'h00);
        digit_seg[2] = SegFont[mm / 10];
        digit_seg[3] = SegFont[mm % 10];
        byte_no = ByteData;
      end
      // a start request clears the divider and puts phase 0 out
      ack_bad  = 1'b0;
      div_q    = '0;
      link_st  = LinkStart;
      phase_no = '0;
      drive_phase();
    end else if (link_st != LinkIdle) begin
      // requests while busy fall through here and count as ticks
      nxt = {1'b0, div_q} + 11'd1;
      lim = (ticks_q == '0) ? 11'd1 : {1'b0, ticks_q};
      if (nxt >= lim) begin
        div_q = '0;
        done  = close_phase(r.dio_sense);
      end else begin
        div_q = nxt[9:0];
      end
    end
    o.clk_level   = pin_clk;
    o.dio_level   = pin_dio;
    o.dio_drive   = pin_drv;
    o.busy_res    = link_st != LinkIdle;
    o.ack_missing = ack_bad;
    o.done_res    = done;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 30);
  endfunction

  // Offer one request; once taken, step the predictor and queue its result
  // (or the hand-typed one for table rows that carry it).
  task automatic push_req(input cdsm_pkg::req_t r, input bit typed,
                          input cdsm_pkg::res_t want);
    cdsm_pkg::res_t got;
    while (take_gap()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    got = predict_pins(r);
    wanted_res_q.push_back(typed ? want : got);
  endtask

  // Tick until the shadow says the sequence is over.
  task automatic run_to_idle(input logic sense);
    cdsm_pkg::req_t r;
    r = '0;
    r.action    = cdsm_pkg::ActTick;
    r.dio_sense = sense;
    while (link_st != LinkIdle) push_req(r, 1'b0, ResIdle);
  endtask

  // Wait for every queued result to be checked, then idle on the clock before going on.
  task automatic settle();
    while (wanted_res_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; only called with the block idle.
  task automatic set_config(input logic [2:0] bright, input logic [9:0] ticks);
    cfg_we   <= 1'b1;
    cfg_idx  <= cdsm_pkg::CfgBrightness;
    cfg_data <= CfgW'(bright);
    @(posedge clk);
    cfg_idx  <= cdsm_pkg::CfgPhaseTicks;
    cfg_data <= CfgW'(ticks);
    @(posedge clk);
    cfg_we   <= 1'b0;
    bright_q = bright;
    ticks_q  = ticks;
  endtask

  // Mostly well-formed traffic: a request when idle, then ticks that walk it
  // through, with rare dropped requests, spare codes and NAKs mixed in.
  function automatic cdsm_pkg::req_t make_req();
    cdsm_pkg::req_t r;
    int   pick;
    pick = $urandom_range(99);
    if (link_st == LinkIdle) begin
      r.action = (pick < 25) ? cdsm_pkg::ActPower : (pick < 85) ? cdsm_pkg::ActShow :
                 (pick < 93) ? cdsm_pkg::ActTick : ActSpare;
    end else begin
      r.action = (pick < 4) ? cdsm_pkg::ActShow : (pick < 6) ? cdsm_pkg::ActPower :
                 (pick < 94) ? cdsm_pkg::ActTick : ActSpare;
    end
    r.hours = ($urandom_range(99) < 15) ? 7'($urandom_range(127, 100)) :
              7'($urandom_range(99));
    r.minutes = ($urandom_range(99) < 15) ? 7'($urandom_range(127, 100)) :
                7'($urandom_range(99));
    r.colon     = 1'($urandom_range(1));
    r.dio_sense = $urandom_range(99) < 6;
    return r;
  endfunction

  task automatic run_random(input int count, input bit drain);
    repeat (count) push_req(make_req(), 1'b0, ResIdle);
    if (drain) run_to_idle(1'b0);
    req_ch.valid <= 1'b0;
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the field-by-field compare
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 30);
  end

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cdsm_pkg::res_t w;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (wanted_res_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        w = wanted_res_q.pop_front();
        check_field("clk_level", w.clk_level, res_ch.payload.clk_level);
        check_field("dio_level", w.dio_level, res_ch.payload.dio_level);
        check_field("dio_drive", w.dio_drive, res_ch.payload.dio_drive);
        check_field("busy_res", w.busy_res, res_ch.payload.busy_res);
        check_field("ack_missing", w.ack_missing, res_ch.payload.ack_missing);
        check_field("done_res", w.done_res, res_ch.payload.done_res);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    cdsm_pkg::req_t r;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = cdsm_pkg::CfgBrightness;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    res_ch.ready   = 1'b0;

    // shadow reset state
    bright_q = 3'd7;
    ticks_q  = 10'd200;
    link_st  = LinkIdle;
    byte_no  = '0;
    phase_no = '0;
    shift_q  = '0;
    foreach (digit_seg[i]) digit_seg[i] = 8'h00;
    div_q    = '0;
    ack_bad  = 1'b0;
    pin_clk  = 1'b1;
    pin_dio  = 1'b1;
    pin_drv  = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: dimmest setting, zero divider (acts as one phase per tick).
    set_config(3'd0, 10'd0);
    for (int i = 0; i < PlanLen; i++) begin
      r.action    = Plan[i].action;
      r.hours     = Plan[i].hours;
      r.minutes   = Plan[i].minutes;
      r.colon     = Plan[i].colon;
      r.dio_sense = Plan[i].sense;
      push_req(r, Plan[i].typed, Plan[i].want);
      if (Plan[i].drain) run_to_idle(Plan[i].sense);
    end
    req_ch.valid <= 1'b0;
    settle();

    // Back-to-back stretch at full brightness, no bubbles on either side.
    set_config(3'd7, 10'd1);
    steady = 1'b1;
    run_random(150, 1'b1);
    steady = 1'b0;

    // Slower divider last: the sequence is left unfinished on purpose.
    set_config(3'd5, 10'd5);
    run_random(100, 1'b0);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cdsm_pkg.sv
hw/rtl/cdsm_stream_if.sv
hw/rtl/cdsm_fifo.sv
hw/rtl/cdsm_front.sv
hw/rtl/cdsm_back.sv
hw/rtl/clock_display_serial_master.sv
hw/rtl/cdsm_checker.sv
test/tb.sv
